// File: rtl/utxo_chunk_record_parser_macros.svh
// Assertion macros used by the chunk record parser core.
`ifndef UTXO_CHUNK_RECORD_PARSER_MACROS_SVH
`define UTXO_CHUNK_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UCRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ucrp assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define UCRP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ucrp assertion failed");

`endif

// File: rtl/ucrp_pkg.sv
// Types, codes and constants of the chunk record parser.
package ucrp_pkg;

    localparam int APB_AW = 3;

    localparam logic [0:0]  REG_MAX_ENTRY_COUNT = 1'b0;
    localparam logic [11:0] MAX_COUNT_RST       = 12'd1000;

    localparam logic [7:0] VARINT_LEN2 = 8'd253;
    localparam logic [7:0] VARINT_LEN4 = 8'd254;

    localparam logic [5:0] COUNT_BYTES  = 6'd4;
    localparam logic [5:0] ID_BYTES     = 6'd32;
    localparam logic [5:0] INDEX_BYTES  = 6'd4;
    localparam logic [5:0] VALUE_BYTES  = 6'd8;
    localparam logic [5:0] HEIGHT_BYTES = 6'd4;
    localparam logic [5:0] LEN2_BYTES   = 6'd2;
    localparam logic [5:0] LEN4_BYTES   = 6'd4;

    typedef enum logic [3:0] {
        PH_COUNT    = 4'd0,
        PH_ID       = 4'd1,
        PH_INDEX    = 4'd2,
        PH_VALUE    = 4'd3,
        PH_HEIGHT   = 4'd4,
        PH_COINBASE = 4'd5,
        PH_LEN      = 4'd6,
        PH_SCRIPT   = 4'd7,
        PH_IGNORE   = 4'd8,
        PH_LEN2     = 4'd9,
        PH_LEN4     = 4'd10
    } t_phase;

    typedef enum logic [3:0] {
        KIND_COUNT    = 4'd0,
        KIND_ID       = 4'd1,
        KIND_INDEX    = 4'd2,
        KIND_VALUE    = 4'd3,
        KIND_HEIGHT   = 4'd4,
        KIND_COINBASE = 4'd5,
        KIND_LENGTH   = 4'd6,
        KIND_SCRIPT   = 4'd7,
        KIND_IGNORED  = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_COUNT = 2'd1,
        ERR_TRUNCATED = 2'd2
    } t_err;

    typedef struct packed {
        t_kind       token_kind;
        logic [7:0]  data_byte;
        logic [63:0] field_value;
        logic        field_done;
        logic [11:0] entry_number;
        logic        entry_done;
        logic        chunk_done;
        t_err        parse_error;
        logic [11:0] entries_parsed;
    } t_token;

endpackage

// File: rtl/ucrp_cfg.sv
// APB register block holding the entry count limit.
module ucrp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ucrp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [11:0]                 o_max_count
);

    logic        reg_hit;
    logic [11:0] r_max_count;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ucrp_pkg::APB_AW-1:2] == ucrp_pkg::REG_MAX_ENTRY_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= ucrp_pkg::MAX_COUNT_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_count <= pwdata[11:0];
        end
    end

    assign prdata      = reg_hit ? {20'd0, r_max_count} : 32'd0;
    assign o_max_count = r_max_count;

endmodule

// File: rtl/ucrp_core.sv
// Parser state and the per-byte token logic.
`include "utxo_chunk_record_parser_macros.svh"

module ucrp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic [11:0]         i_max_count,
    output ucrp_pkg::t_token    o_token
);

    ucrp_pkg::t_phase r_phase,     n_phase;
    logic [5:0]       r_cnt,       n_cnt;
    logic [63:0]      r_acc,       n_acc;
    logic [11:0]      r_expected,  n_expected;
    logic [11:0]      r_completed, n_completed;
    logic [31:0]      r_left,      n_left;
    ucrp_pkg::t_err   r_err,       n_err;

    logic [63:0] acc_ins;
    logic [5:0]  cnt_inc;
    logic [11:0] compl_inc;
    logic [31:0] left_dec;
    logic        do_script;
    logic        do_finish;
    logic [31:0] body_len;

    // The incoming byte lands at its little-endian position in the field.
    assign acc_ins   = r_acc | ({56'd0, i_byte} << {r_cnt[2:0], 3'b000});
    assign cnt_inc   = r_cnt + 6'd1;
    assign compl_inc = r_completed + 12'd1;
    assign left_dec  = r_left - 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_expected  = r_expected;
        n_completed = r_completed;
        n_left      = r_left;
        n_err       = r_err;
        do_script   = 1'b0;
        do_finish   = 1'b0;
        body_len    = 32'd0;

        o_token.token_kind   = ucrp_pkg::KIND_IGNORED;
        o_token.data_byte    = 8'd0;
        o_token.field_value  = 64'd0;
        o_token.field_done   = 1'b0;
        o_token.entry_number = r_completed;
        o_token.entry_done   = 1'b0;
        o_token.chunk_done   = i_last;

        unique case (r_phase)
            ucrp_pkg::PH_COUNT: begin
                o_token.token_kind   = ucrp_pkg::KIND_COUNT;
                o_token.entry_number = 12'd0;
                o_token.field_value  = acc_ins;
                n_acc = acc_ins;
                n_cnt = cnt_inc;
                if (cnt_inc >= ucrp_pkg::COUNT_BYTES) begin
                    o_token.field_done = 1'b1;
                    n_cnt = 6'd0;
                    n_acc = 64'd0;
                    if ((acc_ins[31:0] == 32'd0) ||
                        (acc_ins[31:0] > {20'd0, i_max_count})) begin
                        n_err   = ucrp_pkg::ERR_BAD_COUNT;
                        n_phase = ucrp_pkg::PH_IGNORE;
                    end else begin
                        n_expected = acc_ins[11:0];
                        n_phase    = ucrp_pkg::PH_ID;
                    end
                end
            end
            ucrp_pkg::PH_ID: begin
                o_token.token_kind = ucrp_pkg::KIND_ID;
                o_token.data_byte  = i_byte;
                n_cnt = cnt_inc;
                if (cnt_inc >= ucrp_pkg::ID_BYTES) begin
                    o_token.field_done = 1'b1;
                    n_phase = ucrp_pkg::PH_INDEX;
                    n_cnt   = 6'd0;
                    n_acc   = 64'd0;
                end
            end
            ucrp_pkg::PH_INDEX, ucrp_pkg::PH_VALUE, ucrp_pkg::PH_HEIGHT: begin
                o_token.field_value = acc_ins;
                n_acc = acc_ins;
                n_cnt = cnt_inc;
                if (r_phase == ucrp_pkg::PH_INDEX) begin
                    o_token.token_kind = ucrp_pkg::KIND_INDEX;
                    if (cnt_inc >= ucrp_pkg::INDEX_BYTES) begin
                        o_token.field_done = 1'b1;
                        n_phase = ucrp_pkg::PH_VALUE;
                    end
                end else if (r_phase == ucrp_pkg::PH_VALUE) begin
                    o_token.token_kind = ucrp_pkg::KIND_VALUE;
                    if (cnt_inc >= ucrp_pkg::VALUE_BYTES) begin
                        o_token.field_done = 1'b1;
                        n_phase = ucrp_pkg::PH_HEIGHT;
                    end
                end else begin
                    o_token.token_kind = ucrp_pkg::KIND_HEIGHT;
                    if (cnt_inc >= ucrp_pkg::HEIGHT_BYTES) begin
                        o_token.field_done = 1'b1;
                        n_phase = ucrp_pkg::PH_COINBASE;
                    end
                end
                if (o_token.field_done) begin
                    n_cnt = 6'd0;
                    n_acc = 64'd0;
                end
            end
            ucrp_pkg::PH_COINBASE: begin
                o_token.token_kind  = ucrp_pkg::KIND_COINBASE;
                o_token.field_value = {63'd0, (i_byte != 8'd0)};
                o_token.field_done  = 1'b1;
                n_phase = ucrp_pkg::PH_LEN;
                n_cnt   = 6'd0;
                n_acc   = 64'd0;
            end
            ucrp_pkg::PH_LEN: begin
                o_token.token_kind  = ucrp_pkg::KIND_LENGTH;
                o_token.field_value = {56'd0, i_byte};
                n_cnt = 6'd0;
                n_acc = 64'd0;
                if (i_byte == ucrp_pkg::VARINT_LEN2) begin
                    n_phase = ucrp_pkg::PH_LEN2;
                end else if (i_byte == ucrp_pkg::VARINT_LEN4) begin
                    n_phase = ucrp_pkg::PH_LEN4;
                end else begin
                    o_token.field_done = 1'b1;
                    do_script = 1'b1;
                    body_len  = {24'd0, i_byte};
                end
            end
            ucrp_pkg::PH_LEN2, ucrp_pkg::PH_LEN4: begin
                o_token.token_kind  = ucrp_pkg::KIND_LENGTH;
                o_token.field_value = acc_ins;
                n_acc = acc_ins;
                n_cnt = cnt_inc;
                if (cnt_inc >= ((r_phase == ucrp_pkg::PH_LEN2) ?
                                ucrp_pkg::LEN2_BYTES : ucrp_pkg::LEN4_BYTES)) begin
                    o_token.field_done = 1'b1;
                    do_script = 1'b1;
                    body_len  = acc_ins[31:0];
                end
            end
            ucrp_pkg::PH_SCRIPT: begin
                o_token.token_kind = ucrp_pkg::KIND_SCRIPT;
                o_token.data_byte  = i_byte;
                n_left = left_dec;
                if (left_dec == 32'd0) begin
                    o_token.field_done = 1'b1;
                    do_finish = 1'b1;
                end
            end
            default: begin
                o_token.token_kind = ucrp_pkg::KIND_IGNORED;
            end
        endcase

        // A zero length closes the entry on the length byte itself.
        if (do_script) begin
            if (body_len == 32'd0) begin
                do_finish = 1'b1;
            end else begin
                n_left  = body_len;
                n_phase = ucrp_pkg::PH_SCRIPT;
                n_cnt   = 6'd0;
                n_acc   = 64'd0;
            end
        end

        if (do_finish) begin
            o_token.entry_done = 1'b1;
            n_completed = compl_inc;
            n_phase = (compl_inc >= r_expected) ? ucrp_pkg::PH_IGNORE : ucrp_pkg::PH_ID;
            n_cnt   = 6'd0;
            n_acc   = 64'd0;
        end

        // A chunk that ends before its last counted entry is truncated.
        if (i_last && (n_phase != ucrp_pkg::PH_IGNORE) && (n_err == ucrp_pkg::ERR_NONE)) begin
            n_err = ucrp_pkg::ERR_TRUNCATED;
        end

        o_token.parse_error    = n_err;
        o_token.entries_parsed = n_completed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase     <= ucrp_pkg::PH_COUNT;
            r_cnt       <= 6'd0;
            r_acc       <= 64'd0;
            r_expected  <= 12'd0;
            r_completed <= 12'd0;
            r_left      <= 32'd0;
            r_err       <= ucrp_pkg::ERR_NONE;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_expected  <= n_expected;
            r_completed <= n_completed;
            r_left      <= n_left;
            r_err       <= n_err;
        end
    end

    `UCRP_ASSERT_NXT(a_chunk_end_clears, i_en && i_last,
        (r_phase == ucrp_pkg::PH_COUNT) && (r_completed == 12'd0) && (r_err == ucrp_pkg::ERR_NONE))
    `UCRP_ASSERT_IMP(a_script_left_nonzero, r_phase == ucrp_pkg::PH_SCRIPT, r_left != 32'd0)
    `UCRP_ASSERT_IMP(a_error_ignores, r_err != ucrp_pkg::ERR_NONE, r_phase == ucrp_pkg::PH_IGNORE)
    `UCRP_ASSERT_IMP(a_completed_bounded, 1'b1, r_completed <= r_expected)

endmodule

// File: rtl/utxo_chunk_record_parser.sv
// Top level of the chunk record parser: stream handshake, APB port and pipeline registers.
//
// Usage: chunk bytes enter on the slave stream, one byte per request in s_tdata[7:0],
// with s_tlast high on the final byte of a chunk. Every byte gives exactly one token
// on the master stream; m_tuser carries the token kind and m_tlast repeats the chunk's
// final-byte flag. The entry count limit is written through the APB port at address 0
// while the stream is idle; pready is always high.
// A byte accepted into the input register is parsed from there and its token is captured
// in the token register, from which it is valid on the master side.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// combinational parser update between the input register and the token register.
// When the receiver stalls, the token register holds and the input register takes one
// more byte only if it was empty; s_tready then stays low until the token is taken.
// Reset (synchronous, active low) empties both registers, restores the limit to 1000
// and returns the parser to the count header. After each final byte the parser
// returns to the count header on its own.
module utxo_chunk_record_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] chunk_byte
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [7:0] data_byte, [71:8] field_value, [72] field_done, [84:73] entry_number,
    // [85] entry_done, [87:86] parse_error, [99:88] entries_parsed, [103:100] zero
    output logic [103:0]                o_m_tdata,
    output logic [3:0]                  o_m_tuser,   // [3:0] token_kind
    output logic                        o_m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ucrp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_out_vld;
    ucrp_pkg::t_token r_out;
    ucrp_pkg::t_token tok;
    logic [11:0]      max_count;
    logic             advance;
    logic             parse_en;

    assign advance    = !r_out_vld || i_m_tready;
    assign parse_en   = r_in_vld && advance;
    assign o_s_tready = !r_in_vld || advance;

    ucrp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_count (max_count)
    );

    ucrp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (parse_en),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_max_count (max_count),
        .o_token     (tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_vld <= 1'b1;
        end else if (parse_en) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (parse_en) begin
            r_out <= tok;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out.token_kind;
    assign o_m_tlast  = r_out.chunk_done;
    assign o_m_tdata  = {4'd0, r_out.entries_parsed, r_out.parse_error, r_out.entry_done,
                         r_out.entry_number, r_out.field_done, r_out.field_value,
                         r_out.data_byte};

endmodule
